@@ sv/tts_pkg.sv @@
// Package for the time-to-sample table walker: field structs, opcodes, FSM states.
// Used by tts_div and time_to_sample_table_walker_core.
package tts_pkg;
  localparam int TableDepth = 1024;
  localparam int AddrW = $clog2(TableDepth);
  localparam int CntW = 11;

  localparam logic [1:0] OpLoad = 2'd0;
  localparam logic [1:0] OpT2s = 2'd1;
  localparam logic [1:0] OpS2t = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [9:0] entry_index;
    logic [31:0] run_count;
    logic [31:0] run_duration;
    logic [31:0] query_value;
  } in_t;

  typedef struct packed {
    logic found;
    logic [31:0] answer;
  } out_t;

  typedef enum logic [3:0] {
    StIdle, StRead, StCheck, StMul, StStep, StDiv, StFinish, StDone
  } state_t;

  typedef struct packed {
    logic start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;
endpackage

@@ sv/tts_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module tts_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ sv/tts_div.sv @@
// Restoring radix-2 divider, 32-bit quotient.
// Depends on tts_pkg.
module tts_div (
  input  logic              clk,
  input  logic              rst,
  input  tts_pkg::div_req_t req,
  output logic              busy,
  output logic [31:0]       quotient
);
  logic [31:0] rem, quo, dvs;
  logic [5:0]  cnt;
  logic [32:0] trial;
  assign trial = {rem, quo[31]} - {1'b0, dvs};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
      cnt <= 6'd32;
    end else if (busy) begin
      if (trial[32]) begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end else begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end
  assign quotient = quo;
endmodule

@@ sv/time_to_sample_table_walker_core.sv @@
// Time-to-sample table walker: run table in RAM, forward and reverse cursors.
// A load writes one entry, no result; an S2t query that hits the cache gives the cached
// time; else entries are read and multiplied to the match, then divide (fwd) or finish.
// One item at a time; each walk step reads the table RAM port, then multiplies.
// Reset: synchronous rst clears cursors, cache, entry_count; table content undefined.
// Depends on tts_pkg, tts_ram, tts_div.
module time_to_sample_table_walker_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  tts_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tts_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [10:0]   cfg_data
);
  tts_pkg::state_t state, state_next;
  tts_pkg::in_t item;
  logic [tts_pkg::CntW-1:0] entry_count;
  logic [10:0] fwd_cur, rev_cur;
  logic [31:0] fwd_tb, fwd_sb, rev_tb, rev_sb, c_s, c_t;
  logic [31:0] cnt, dur, prod;
  logic [63:0] rdata;
  logic [10:0] limit, cur;
  logic is_fwd, accept, rst_walk;
  logic cache_hit;
  logic we;
  logic [tts_pkg::AddrW-1:0] addr;
  tts_pkg::div_req_t dreq;
  logic dbusy;
  logic [31:0] quo;

  assign cfg_ready = 1'b1;
  assign accept = in_valid && !in_stall;
  assign in_stall = (state != tts_pkg::StIdle);
  assign is_fwd = (item.operation == tts_pkg::OpT2s);
  assign limit = (entry_count > 11'(tts_pkg::TableDepth)) ? 11'(tts_pkg::TableDepth)
                                                          : entry_count;
  assign cur = is_fwd ? fwd_cur : rev_cur;
  assign cnt = rdata[63:32];
  assign dur = rdata[31:0];
  assign we = accept && in_data.operation == tts_pkg::OpLoad
              && {1'b0, in_data.entry_index} < 11'(tts_pkg::TableDepth);
  assign addr = accept ? in_data.entry_index[tts_pkg::AddrW-1:0] : cur[tts_pkg::AddrW-1:0];

  tts_ram #(.Width(64), .Depth(tts_pkg::TableDepth)) u_ram (
    .clk(clk), .we(we), .addr(addr),
    .wdata({in_data.run_count, in_data.run_duration}), .rdata(rdata));

  assign dreq.start = (state == tts_pkg::StStep) && is_fwd && fwd_tb + prod >= item.query_value
                      && dur != 32'd0;
  assign dreq.dividend = item.query_value - fwd_tb;
  assign dreq.divisor = dur;
  tts_div u_div (.clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .quotient(quo));

  // walker reset at acceptance: any load, or a query behind its cursor
  always_comb begin
    rst_walk = 1'b0;
    if (accept) begin
      case (in_data.operation)
        tts_pkg::OpLoad: rst_walk = 1'b1;
        tts_pkg::OpT2s:  rst_walk = in_data.query_value < fwd_tb;
        tts_pkg::OpS2t:  rst_walk = c_s != in_data.query_value && in_data.query_value < rev_sb;
        default:         rst_walk = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tts_pkg::StIdle:
        if (accept && (in_data.operation == tts_pkg::OpT2s
                       || in_data.operation == tts_pkg::OpS2t)) state_next = tts_pkg::StRead;
      tts_pkg::StRead:
        if (cache_hit) state_next = tts_pkg::StDone;
        else state_next = tts_pkg::StCheck;
      tts_pkg::StCheck:
        if (cur >= limit) state_next = tts_pkg::StDone;
        else state_next = tts_pkg::StMul;
      tts_pkg::StMul: state_next = tts_pkg::StStep;
      tts_pkg::StStep:
        if (is_fwd) begin
          if (fwd_tb + prod < item.query_value) state_next = tts_pkg::StRead;
          else if (dur != 32'd0) state_next = tts_pkg::StDiv;
          else state_next = tts_pkg::StDone;
        end else begin
          if (rev_sb + cnt < item.query_value) state_next = tts_pkg::StRead;
          else state_next = tts_pkg::StFinish;
        end
      tts_pkg::StDiv: if (!dbusy) state_next = tts_pkg::StDone;
      tts_pkg::StFinish: state_next = tts_pkg::StDone;
      tts_pkg::StDone: if (!out_stall) state_next = tts_pkg::StIdle;
      default: state_next = tts_pkg::StIdle;
    endcase
  end

  assign out_valid = (state == tts_pkg::StDone);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tts_pkg::StIdle;
      entry_count <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) entry_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || rst_walk) begin
      fwd_cur <= '0; fwd_tb <= '0; fwd_sb <= 32'd1;
      rev_cur <= '0; rev_tb <= '0; rev_sb <= 32'd1;
      c_s <= '0; c_t <= '0;
    end else begin
      case (state)
        tts_pkg::StRead:
          if (cache_hit) begin
            out_data <= '{found: 1'b1, answer: c_t};
          end
        tts_pkg::StCheck:
          if (cur >= limit) out_data <= '{found: 1'b0, answer: 32'd0};
        tts_pkg::StMul:
          prod <= is_fwd ? cnt * dur : (item.query_value - rev_sb) * dur;
        tts_pkg::StStep:
          if (is_fwd) begin
            if (fwd_tb + prod < item.query_value) begin
              fwd_tb <= fwd_tb + prod; fwd_sb <= fwd_sb + cnt; fwd_cur <= fwd_cur + 11'd1;
            end else begin
              out_data <= '{found: 1'b1, answer: fwd_sb};
            end
          end else if (rev_sb + cnt < item.query_value) begin
            rev_tb <= rev_tb + cnt * dur; rev_sb <= rev_sb + cnt; rev_cur <= rev_cur + 11'd1;
          end else begin
            out_data <= '{found: 1'b1, answer: rev_tb + prod};
          end
        tts_pkg::StDiv:
          if (!dbusy) out_data.answer <= fwd_sb + quo;
        tts_pkg::StFinish: begin
          c_s <= item.query_value; c_t <= out_data.answer;
        end
        default: ;
      endcase
    end
  end

  // cache is tested against its value before any walker reset
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
      cache_hit <= in_data.operation == tts_pkg::OpS2t && c_s == in_data.query_value;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    state != tts_pkg::StIdle |-> in_stall) else $error("accept while busy");
  a_cur_limit: assert property (@(posedge clk) disable iff (rst)
    fwd_cur <= 11'(tts_pkg::TableDepth) && rev_cur <= 11'(tts_pkg::TableDepth))
    else $error("cursor past table");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("result dropped");
`endif
endmodule
